FILE: design/software_timer_slot_table_macros.svh
// assertion macros shared by the timer slot table checker
// no dependencies; included by files that carry concurrent assertions
`ifndef SOFTWARE_TIMER_SLOT_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define STST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define STST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/stst_pkg.sv
// types, codes and defaults for the timer slot table
// no dependencies; used by the top level and its checker
`default_nettype none

package stst_pkg;

    // default configuration
    localparam int SLOT_COUNT_DEF = 32;
    localparam int TICK_BITS_DEF  = 32;
    localparam int HDL_W          = 5;

    // action codes of an input transaction
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // kind codes of a result transaction
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic [1:0]       action;
        logic [31:0]      now_tick;
        logic [31:0]      delay_ticks;
        logic [HDL_W-1:0] slot_handle;
        logic [31:0]      handler_tag;
        logic [31:0]      param_tag;
        logic [31:0]      context_tag;
    } t_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [HDL_W-1:0] handle_out;
        logic [31:0]      fired_handler;
        logic [31:0]      fired_param;
        logic [31:0]      fired_context;
        logic             last;
    } t_out;

    // caller tags kept per slot
    typedef struct packed {
        logic [31:0] handler;
        logic [31:0] param;
        logic [31:0] ctx;
    } t_tags;

endpackage

`default_nettype wire

FILE: design/software_timer_slot_table.sv
// timer slot table top level: slot busy bits, deadline and tag memory, scan sequencer
// depends on stst_pkg
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------
//  input   | in        | i_in_valid / o_in_stall | i_in  (stst_pkg::t_in)
//  output  | out       | o_out_valid / i_out_stall | o_out (stst_pkg::t_out)
//
// one transaction is worked at a time; o_in_stall is high until its last result is registered
// start: one slot busy bit tested per cycle from slot 1
// tick: one memory read and one subtract per slot
// an output stall holds the sequencer whenever a new result must wait for the output register
// reset clears the busy bits at once; deadline and tag memory needs no clearing pass
`default_nettype none

module software_timer_slot_table #(
    parameter int SLOT_COUNT = stst_pkg::SLOT_COUNT_DEF,
    parameter int TICK_BITS  = stst_pkg::TICK_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire stst_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output stst_pkg::t_out     o_out
);
    import stst_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_CANCEL = 2'd2;
    localparam logic [1:0] ST_SCAN   = 2'd3;

    // control state
    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [SLOT_COUNT-1:0] r_busy, n_busy;
    logic                  r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic                  r_out_vld, n_out_vld;
    t_out                  r_out, n_out;

    // latched transaction payload
    logic [TICK_BITS-1:0]  r_now;
    logic [TICK_BITS-1:0]  r_dly;
    logic [HDL_W-1:0]      r_hdl;
    t_tags                 r_tag;

    // slot memory and its read register
    logic [TICK_BITS-1:0]  r_mem_dl  [SLOT_COUNT];
    t_tags                 r_mem_tag [SLOT_COUNT];
    logic [TICK_BITS-1:0]  r_rd_dl;
    t_tags                 r_rd_tag;

    logic                  mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_addr;
    logic [TICK_BITS-1:0]  add_b;
    logic                  add_cin;
    logic [TICK_BITS-1:0]  add_sum;
    logic                  out_free;
    logic                  cur_busy;
    logic                  expired;
    logic                  emit_fire;
    logic                  scan_hold;
    logic                  scan_end;
    logic                  at_end;
    logic                  hdl_ok;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // shared adder: now + delay on start, now - deadline on tick
    assign add_b   = (r_state == ST_SCAN) ? ~r_rd_dl : r_dly;
    assign add_cin = (r_state == ST_SCAN);
    assign add_sum = r_now + add_b + TICK_BITS'(add_cin);

    assign mem_addr  = r_idx[IDX_W-1:0];
    assign out_free  = !r_out_vld || !i_out_stall;
    assign at_end    = (r_idx == CNT_W'(SLOT_COUNT));
    assign cur_busy  = r_busy[mem_addr];
    assign expired   = r_rd_vld && r_busy[r_rd_idx] && !add_sum[TICK_BITS-1];
    assign emit_fire = expired && (r_rd_tag.handler != '0);
    assign scan_hold = emit_fire && !out_free;
    assign scan_end  = !r_rd_vld && at_end;
    assign hdl_ok    = (r_hdl != '0) && (int'(r_hdl) < SLOT_COUNT);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_busy    = r_busy;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.action)
                        ACT_START: begin
                            n_state = ST_START;
                            n_idx   = CNT_W'(1);
                        end
                        ACT_CANCEL: begin
                            n_state = ST_CANCEL;
                        end
                        ACT_TICK: begin
                            n_state  = ST_SCAN;
                            n_idx    = CNT_W'(1);
                            n_rd_vld = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_START: begin
                // lowest free slot, one per cycle
                if (at_end) begin
                    if (out_free) begin
                        n_out_vld = 1'b1;
                        n_out     = '{kind: KIND_START, handle_out: '0, fired_handler: '0,
                                      fired_param: '0, fired_context: '0, last: 1'b1};
                        n_state   = ST_IDLE;
                    end
                end else if (!cur_busy) begin
                    if (out_free) begin
                        mem_we           = 1'b1;
                        n_busy[mem_addr] = 1'b1;
                        n_out_vld        = 1'b1;
                        n_out            = '{kind: KIND_START, handle_out: HDL_W'(r_idx),
                                             fired_handler: '0, fired_param: '0,
                                             fired_context: '0, last: 1'b1};
                        n_state          = ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_CANCEL: begin
                if (out_free) begin
                    if (hdl_ok) begin
                        n_busy[IDX_W'(r_hdl)] = 1'b0;
                    end
                    n_out_vld = 1'b1;
                    n_out     = '{kind: KIND_CANCEL, handle_out: r_hdl, fired_handler: '0,
                                  fired_param: '0, fired_context: '0, last: 1'b1};
                    n_state   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    if (out_free) begin
                        n_out_vld = 1'b1;
                        n_out     = '{kind: KIND_DONE, handle_out: '0, fired_handler: '0,
                                      fired_param: '0, fired_context: '0, last: 1'b1};
                        n_state   = ST_IDLE;
                    end
                end else if (!scan_hold) begin
                    // evaluate the slot held in the read register
                    if (expired) begin
                        n_busy[r_rd_idx] = 1'b0;
                    end
                    if (emit_fire) begin
                        n_out_vld = 1'b1;
                        n_out     = '{kind: KIND_FIRED, handle_out: HDL_W'(r_rd_idx),
                                      fired_handler: r_rd_tag.handler,
                                      fired_param: r_rd_tag.param,
                                      fired_context: r_rd_tag.ctx, last: 1'b0};
                    end
                    // issue the read of the next slot
                    if (!at_end) begin
                        mem_re   = 1'b1;
                        n_rd_vld = 1'b1;
                        n_rd_idx = mem_addr;
                        n_idx    = r_idx + CNT_W'(1);
                    end else begin
                        n_rd_vld = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_busy    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_idx  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_busy    <= n_busy;
            r_rd_vld  <= n_rd_vld;
            r_rd_idx  <= n_rd_idx;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_in_valid && !o_in_stall) begin
            r_now <= TICK_BITS'(i_in.now_tick);
            r_dly <= TICK_BITS'(i_in.delay_ticks);
            r_hdl <= i_in.slot_handle;
            r_tag <= '{handler: i_in.handler_tag, param: i_in.param_tag,
                       ctx: i_in.context_tag};
        end
    end

    // slot memory, one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_dl[mem_addr]  <= add_sum;
            r_mem_tag[mem_addr] <= r_tag;
        end
        if (mem_re) begin
            r_rd_dl  <= r_mem_dl[mem_addr];
            r_rd_tag <= r_mem_tag[mem_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/stst_checker.sv
// port-level checker for the timer slot table, bound to the top level
// depends on stst_pkg and software_timer_slot_table_macros.svh
`default_nettype none
`include "software_timer_slot_table_macros.svh"

module stst_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_stall,
    input  wire stst_pkg::t_in  i_in,
    input  wire logic           i_out_valid,
    input  wire logic           i_out_stall,
    input  wire stst_pkg::t_out i_out
);
    import stst_pkg::*;

    // a held result keeps its payload
    `STST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out), "result dropped or changed while stalled")

    // any transaction with a real action closes the input side while it is worked
    `STST_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall && (i_in.action == ACT_START || i_in.action == ACT_CANCEL || i_in.action == ACT_TICK), i_in_stall, "input not stalled after accepted transaction")

    // only fired results are not last
    `STST_ASSERT_NOW(a_last_kind, i_clk, i_rst_n, i_out_valid, i_out.last == (i_out.kind != KIND_FIRED), "last flag does not match result kind")

    // a fired result names a real slot and a nonzero handler
    `STST_ASSERT_NOW(a_fired_fields, i_clk, i_rst_n, i_out_valid && (i_out.kind == KIND_FIRED), (i_out.handle_out != '0) && (i_out.fired_handler != '0), "fired result with zero slot or handler")

endmodule

bind software_timer_slot_table stst_checker u_stst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in        (i_in),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

`default_nettype wire
